### hw/rtl/tof_pkg.sv
// Shared constants and types for the thermal occupation factor pipeline.
`timescale 1ns / 1ps

package tof_pkg;

    // Default parameter values
    localparam int FRAC_BITS_DEF = 16;
    localparam int EXP_DEPTH_DEF = 256;

    // Statistics modes; any other code runs as Boltzmann
    localparam logic [1:0] MODE_BOSE  = 2'd1;
    localparam logic [1:0] MODE_FERMI = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_STAT_MODE = 2'd0;
    localparam logic [1:0] CFG_BETA      = 2'd1;
    localparam logic [1:0] CFG_MU        = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_EXACT = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_POLE  = 2'd2;

    localparam logic [31:0] BETA_RESET = 32'd65536;

    // ln2 and 1.0 with 30 fraction bits
    localparam logic [63:0] LN2_30 = 64'd744261118;
    localparam logic [30:0] ONE30  = 31'h4000_0000;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // How the final stage forms the result
    typedef enum logic [2:0] {
        RK_POLE,
        RK_SAT_POS,
        RK_SAT_NEG,
        RK_DIRECT,
        RK_QUOT_POS,
        RK_QUOT_NEG
    } res_kind_t;

    // Per-item flags carried down the front pipeline
    typedef struct packed {
        logic bose;
        logic fermi;
        logic d_neg;
        logic d_zero;
    } item_info_t;

    // Per-item control carried through the divider
    typedef struct packed {
        res_kind_t   kind;
        logic [31:0] direct;
    } res_ctl_t;

endpackage

### hw/rtl/thermal_occupation_factor.sv
// Thermal occupation factor: Boltzmann, Bose-Einstein or Fermi-Dirac, one energy per
// cycle while s_tready is high.
// Input stream s_*: one signed 32-bit energy per transaction on s_tdata.
// Output stream m_*: the signed Q(FRAC_BITS) occupation factor on m_tdata and
// the status (exact, saturated, Bose-Einstein pole) on m_tuser.
// Config port: cfg_we/cfg_index/cfg_data write stat_mode, beta and mu; write
// only while no transaction is in flight.
// Throughput: one transaction per cycle while s_tready is high. The 50 stages
// are the exponent product, the ln2 range reduction, the table interpolation, a
// restoring divider that resolves one quotient bit per stage, and the final
// saturation stage; the output register follows them.
// Stall: an output register plus one skid entry sit behind the pipeline; the
// pipeline freezes as a whole (s_tready low) only while the skid entry is full,
// so nothing is dropped or repeated.
// Reset: registers return to Boltzmann, beta = 1.0 (65536), mu = 0, and the
// pipeline and output buffer are emptied.
`timescale 1ns / 1ps

module thermal_occupation_factor
    import tof_pkg::*;
#(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] energy_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] occupation
    output logic [1:0]  m_tuser,    // [1:0] status
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW     = FRAC_BITS + 7;
    localparam int SH30   = 30 - FRAC_BITS;
    localparam int IW     = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int NW     = FRAC_BITS + 31;
    localparam int JMW    = IW + 3;
    localparam int RDW    = 30 + IW;
    localparam int JPW    = 30 + JMW;
    localparam int NST    = 50;
    localparam int DV_LAST = 32;

    localparam logic [AW-1:0]  ACLAMP   = AW'(64 << FRAC_BITS);
    localparam logic [29:0]    LN2_C    = LN2_30[29:0];
    localparam logic [10:0]    K_RECIP  = 11'((64'd1 << 40) / LN2_30);
    localparam logic [JMW-1:0] J_RECIP  = JMW'((64'(EXP_TABLE_DEPTH) << 32) / LN2_30);
    localparam logic [32:0]    Q_RECIP  = 33'((64'd1 << 62) / LN2_30);
    localparam logic [NW-1:0]  SCALE    = {1'b1, {(30 + FRAC_BITS){1'b0}}};
    localparam logic [30:0]    HALF_LSB = 31'(1) << (29 - FRAC_BITS);

    // exp(-i*ln2/DEPTH) at 30 fraction bits, truncated Taylor series
    function automatic logic [30:0] exp_rom_entry(input int idx);
        logic [63:0] y;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        y    = (64'(idx) * LN2_30) / 64'(EXP_TABLE_DEPTH);
        pos  = 64'(ONE30);
        neg  = '0;
        term = 64'(ONE30);
        for (int n = 1; n <= 20; n++) begin
            term = ((term * y) >> 30) / 64'(n);
            if (n[0])
                neg = neg + term;
            else
                pos = pos + term;
        end
        return (pos > neg) ? 31'(pos - neg) : 31'(0);
    endfunction

    // Constant exponential table
    logic [30:0] exp_rom [0:EXP_TABLE_DEPTH];

    genvar gr;
    generate
        for (gr = 0; gr <= EXP_TABLE_DEPTH; gr++)
        begin : g_rom
            assign exp_rom[gr] = exp_rom_entry(gr);
        end
    endgenerate

    // Configuration registers
    logic [1:0]  stat_mode_reg;
    logic [31:0] beta_reg;
    logic [31:0] mu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_mode_reg <= '0;
            beta_reg      <= BETA_RESET;
            mu_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STAT_MODE: stat_mode_reg <= cfg_data[1:0];
                CFG_BETA:      beta_reg      <= cfg_data;
                CFG_MU:        mu_reg        <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Pipeline advance: frozen only while the skid entry is occupied
    logic           pipe_en;
    logic           push;
    logic [NST-1:0] vld_reg;
    logic           skid_valid_reg;
    logic           out_valid_reg;

    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;
    assign push     = vld_reg[NST-1] && pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (pipe_en)
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
    end

    // Stage data registers and next values
    item_info_t   s1_info_next;
    logic [32:0]  s1_d;
    logic [32:0]  mu_ext;
    logic [31:0]  s1_mag_next, s1_mag_reg;
    item_info_t   info_reg [1:15];
    logic [47:0]  s2_pl_next, s2_pl_reg;
    logic [47:0]  s2_ph_next, s2_ph_reg;
    logic [63:0]  s3_prod;
    logic [AW-1:0] s3_a_next, s3_a_reg;
    logic [36:0]  s4_a30_next, s4_a30_reg;
    logic [47:0]  s4_kp;
    logic [6:0]   s4_kest_next, s4_kest_reg;
    logic [36:0]  s5_kl, s5_r0_full;
    logic [30:0]  s5_r0_next, s5_r0_reg;
    logic [6:0]   s5_kest_reg;
    logic         s6_ge;
    logic [29:0]  s6_r_next, s6_r_reg;
    logic [6:0]   s6_k_next;
    logic [6:0]   kc_reg [6:14];
    logic [RDW-1:0] s7_rd_next, s7_rd_reg;
    logic [JPW-1:0] s7_jp;
    logic [IW-1:0]  s7_jest_next, s7_jest_reg;
    logic [RDW-1:0] s8_jl, s8_rem0_full;
    logic [30:0]  s8_rem0_next, s8_rem0_reg;
    logic [IW-1:0] s8_jest_reg;
    logic         s9_ge;
    logic [IW-1:0] s9_j_next, s9_j_reg;
    logic [29:0]  s9_rem_next, s9_rem_reg;
    logic [30:0]  lo_reg [10:13];
    logic [30:0]  s10_hi_reg;
    logic [29:0]  s10_rem_reg;
    logic [29:0]  s11_diff;
    logic [59:0]  s11_p_next, s11_p_reg;
    logic [64:0]  s12_qp;
    logic [29:0]  s12_qest_next, s12_qest_reg;
    logic [59:0]  s12_p_reg;
    logic [59:0]  s13_ql;
    logic [30:0]  s13_r3_next, s13_r3_reg;
    logic [29:0]  s13_qest_reg;
    logic [30:0]  s14_q;
    logic [30:0]  s14_v_next, s14_v_reg;
    logic [30:0]  s15_u_next, s15_u_reg;
    logic [31:0]  s16_den_next, s16_den_reg;
    logic [NW-1:0] s16_base;
    logic [NW-1:0] s16_n_next, s16_n_reg;
    res_ctl_t     s16_ctl_next, s16_ctl_reg;

    // Front pipeline datapath
    always_comb
    begin
        // S1: d = E - mu (E alone in Boltzmann), magnitude and sign
        s1_info_next.bose  = (stat_mode_reg == MODE_BOSE);
        s1_info_next.fermi = (stat_mode_reg == MODE_FERMI);
        mu_ext = (s1_info_next.bose || s1_info_next.fermi) ? {mu_reg[31], mu_reg} : 33'd0;
        s1_d   = {s_tdata[31], s_tdata} - mu_ext;
        s1_info_next.d_neg  = s1_d[32];
        s1_info_next.d_zero = (s1_d == 33'd0);
        s1_mag_next = s1_d[32] ? 32'(-s1_d) : s1_d[31:0];

        // S2: |d| * beta as two partial products
        s2_pl_next = 48'(s1_mag_reg) * 48'(beta_reg[15:0]);
        s2_ph_next = 48'(s1_mag_reg) * 48'(beta_reg[31:16]);

        // S3: sum and clamp at 64.0
        s3_prod   = 64'(s2_pl_reg) + {s2_ph_reg, 16'd0};
        s3_a_next = (s3_prod > 64'(ACLAMP)) ? ACLAMP : s3_prod[AW-1:0];

        // S4: k estimate = a / ln2 by reciprocal
        s4_a30_next  = {s3_a_reg, {SH30{1'b0}}};
        s4_kp        = 48'(s4_a30_next) * 48'(K_RECIP);
        s4_kest_next = s4_kp[46:40];

        // S5: residue for the estimate
        s5_kl      = 37'(s4_kest_reg) * 37'(LN2_C);
        s5_r0_full = s4_a30_reg - s5_kl;
        s5_r0_next = s5_r0_full[30:0];

        // S6: one correction step
        s6_ge     = (s5_r0_reg >= 31'(LN2_C));
        s6_r_next = s6_ge ? 30'(s5_r0_reg - 31'(LN2_C)) : s5_r0_reg[29:0];
        s6_k_next = s5_kest_reg + 7'(s6_ge);

        // S7: table index estimate
        s7_rd_next   = RDW'(s6_r_reg) * RDW'(EXP_TABLE_DEPTH);
        s7_jp        = JPW'(s6_r_reg) * JPW'(J_RECIP);
        s7_jest_next = s7_jp[32 +: IW];

        // S8: interpolation remainder for the estimate
        s8_jl        = RDW'(s7_jest_reg) * RDW'(LN2_C);
        s8_rem0_full = s7_rd_reg - s8_jl;
        s8_rem0_next = s8_rem0_full[30:0];

        // S9: one correction step
        s9_ge       = (s8_rem0_reg >= 31'(LN2_C));
        s9_j_next   = s8_jest_reg + IW'(s9_ge);
        s9_rem_next = s9_ge ? 30'(s8_rem0_reg - 31'(LN2_C)) : s8_rem0_reg[29:0];

        // S11: slope times remainder
        s11_diff   = 30'(lo_reg[10] - s10_hi_reg);
        s11_p_next = 60'(s11_diff) * 60'(s10_rem_reg);

        // S12: quotient estimate of p / ln2
        s12_qp        = 65'(s11_p_reg[59:28]) * 65'(Q_RECIP);
        s12_qest_next = s12_qp[34 +: 30];

        // S13: remainder for the estimate
        s13_ql      = 60'(s12_qest_reg) * 60'(LN2_C);
        s13_r3_next = 31'(s12_p_reg - s13_ql);

        // S14: corrected step, interpolated exp(-r)
        s14_q      = 31'(s13_qest_reg) + 31'(s13_r3_reg >= 31'(LN2_C));
        s14_v_next = lo_reg[13] - s14_q;

        // S15: scale by 2^-k
        s15_u_next = (kc_reg[14] >= 7'd31) ? 31'd0 : (s14_v_reg >> kc_reg[14]);

        // S16: pick dividend, divisor and result form
        if (info_reg[15].bose)
            s16_den_next = 32'(ONE30) - 32'(s15_u_reg);
        else if (info_reg[15].fermi)
            s16_den_next = 32'(ONE30) + 32'(s15_u_reg);
        else
            s16_den_next = 32'(s15_u_reg);

        if ((info_reg[15].bose || info_reg[15].fermi) && !info_reg[15].d_neg)
            s16_base = NW'(s15_u_reg) << FRAC_BITS;
        else
            s16_base = SCALE;
        s16_n_next = s16_base + NW'(s16_den_next >> 1);

        s16_ctl_next.direct = 32'((s15_u_reg + HALF_LSB) >> SH30);
        if (info_reg[15].bose)
        begin
            if (info_reg[15].d_zero)
                s16_ctl_next.kind = RK_POLE;
            else if (s16_den_next == 32'd0)
                s16_ctl_next.kind = info_reg[15].d_neg ? RK_SAT_NEG : RK_SAT_POS;
            else
                s16_ctl_next.kind = info_reg[15].d_neg ? RK_QUOT_NEG : RK_QUOT_POS;
        end
        else if (info_reg[15].fermi)
            s16_ctl_next.kind = RK_QUOT_POS;
        else if (!info_reg[15].d_neg)
            s16_ctl_next.kind = RK_DIRECT;
        else if (s15_u_reg == 31'd0)
            s16_ctl_next.kind = RK_SAT_POS;
        else
            s16_ctl_next.kind = RK_QUOT_POS;
    end

    // Front pipeline registers
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            info_reg[1] <= s1_info_next;
            for (int i = 2; i <= 15; i++)
                info_reg[i] <= info_reg[i-1];
            s1_mag_reg   <= s1_mag_next;
            s2_pl_reg    <= s2_pl_next;
            s2_ph_reg    <= s2_ph_next;
            s3_a_reg     <= s3_a_next;
            s4_a30_reg   <= s4_a30_next;
            s4_kest_reg  <= s4_kest_next;
            s5_r0_reg    <= s5_r0_next;
            s5_kest_reg  <= s4_kest_reg;
            s6_r_reg     <= s6_r_next;
            kc_reg[6]    <= s6_k_next;
            for (int i = 7; i <= 14; i++)
                kc_reg[i] <= kc_reg[i-1];
            s7_rd_reg    <= s7_rd_next;
            s7_jest_reg  <= s7_jest_next;
            s8_rem0_reg  <= s8_rem0_next;
            s8_jest_reg  <= s7_jest_reg;
            s9_j_reg     <= s9_j_next;
            s9_rem_reg   <= s9_rem_next;
            // S10: table read of both neighbors
            lo_reg[10]   <= exp_rom[s9_j_reg];
            s10_hi_reg   <= exp_rom[s9_j_reg + IW'(1)];
            s10_rem_reg  <= s9_rem_reg;
            for (int i = 11; i <= 13; i++)
                lo_reg[i] <= lo_reg[i-1];
            s11_p_reg    <= s11_p_next;
            s12_qest_reg <= s12_qest_next;
            s12_p_reg    <= s11_p_reg;
            s13_r3_reg   <= s13_r3_next;
            s13_qest_reg <= s12_qest_reg;
            s14_v_reg    <= s14_v_next;
            s15_u_reg    <= s15_u_next;
            s16_den_reg  <= s16_den_next;
            s16_n_reg    <= s16_n_next;
            s16_ctl_reg  <= s16_ctl_next;
        end
    end

    // Restoring divider: overflow check, then one quotient bit per stage
    logic [NW-1:0] dv_rem_reg [0:DV_LAST];
    logic [31:0]   dv_den_reg [0:DV_LAST];
    logic [31:0]   dv_q_reg   [0:DV_LAST];
    logic          dv_ovf_reg [0:DV_LAST];
    res_ctl_t      dv_ctl_reg [0:DV_LAST];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            dv_rem_reg[0] <= s16_n_reg;
            dv_den_reg[0] <= s16_den_reg;
            dv_q_reg[0]   <= '0;
            dv_ovf_reg[0] <= (64'(s16_n_reg) >= {s16_den_reg, 32'd0});
            dv_ctl_reg[0] <= s16_ctl_reg;
        end
    end

    genvar gs;
    generate
        for (gs = 1; gs <= DV_LAST; gs++)
        begin : g_div
            localparam int B = DV_LAST - gs;
            logic [63:0] dv_shift;
            logic        dv_fit;

            assign dv_shift = 64'(dv_den_reg[gs-1]) << B;
            assign dv_fit   = (64'(dv_rem_reg[gs-1]) >= dv_shift);

            always_ff @(posedge clk)
            begin
                if (pipe_en)
                begin
                    dv_rem_reg[gs] <= dv_fit ? NW'(64'(dv_rem_reg[gs-1]) - dv_shift)
                                             : dv_rem_reg[gs-1];
                    dv_q_reg[gs]   <= dv_q_reg[gs-1] | (dv_fit ? (32'd1 << B) : 32'd0);
                    dv_den_reg[gs] <= dv_den_reg[gs-1];
                    dv_ovf_reg[gs] <= dv_ovf_reg[gs-1];
                    dv_ctl_reg[gs] <= dv_ctl_reg[gs-1];
                end
            end
        end
    endgenerate

    // Final stage: saturation and sign
    logic [31:0] fin_res_next, fin_res_reg;
    logic [1:0]  fin_st_next, fin_st_reg;
    logic [31:0] fin_q;
    logic        fin_ovf;

    always_comb
    begin
        fin_q        = dv_q_reg[DV_LAST];
        fin_ovf      = dv_ovf_reg[DV_LAST];
        fin_res_next = fin_q;
        fin_st_next  = ST_EXACT;
        case (dv_ctl_reg[DV_LAST].kind)
            RK_POLE:
            begin
                fin_res_next = SAT_POS;
                fin_st_next  = ST_POLE;
            end
            RK_SAT_POS:
            begin
                fin_res_next = SAT_POS;
                fin_st_next  = ST_SAT;
            end
            RK_SAT_NEG:
            begin
                fin_res_next = SAT_NEG;
                fin_st_next  = ST_SAT;
            end
            RK_DIRECT:
                fin_res_next = dv_ctl_reg[DV_LAST].direct;
            RK_QUOT_POS:
            begin
                if (fin_ovf || fin_q[31])
                begin
                    fin_res_next = SAT_POS;
                    fin_st_next  = ST_SAT;
                end
            end
            RK_QUOT_NEG:
            begin
                if (fin_ovf || (fin_q > SAT_NEG))
                begin
                    fin_res_next = SAT_NEG;
                    fin_st_next  = ST_SAT;
                end
                else
                    fin_res_next = -fin_q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            fin_res_reg <= fin_res_next;
            fin_st_reg  <= fin_st_next;
        end
    end

    // Output register with one skid entry
    logic [31:0] out_data_reg, skid_data_reg;
    logic [1:0]  out_user_reg, skid_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= push;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
            else
            begin
                out_data_reg <= fin_res_reg;
                out_user_reg <= fin_st_reg;
            end
        end
        else if (push)
        begin
            skid_data_reg <= fin_res_reg;
            skid_user_reg <= fin_st_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_pole_bose_only: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_POLE) |-> (stat_mode_reg == MODE_BOSE && m_tdata == SAT_POS))
        else $error("pole status outside Bose-Einstein mode");

    a_fermi_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && stat_mode_reg == MODE_FERMI) |-> (m_tuser == ST_EXACT))
        else $error("Fermi-Dirac result flagged as saturated");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NST-2] && !dv_ovf_reg[DV_LAST])
            |-> (64'(dv_rem_reg[DV_LAST]) < 64'(dv_den_reg[DV_LAST])))
        else $error("divider remainder not below divisor");

endmodule

### tb/tb_thermal_occupation_factor.sv
// Self-checking testbench for the thermal occupation factor stream block.
`timescale 1ns / 1ps

module tb_thermal_occupation_factor
    import tof_pkg::*;
;

    localparam int FB = 16;
    localparam int DEPTH = 256;
    localparam logic [63:0] CLAMP_A = 64'd64 << FB;
    localparam int LATENCY = 50;
    localparam longint CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    typedef struct packed {
        logic [31:0] occ;
        logic [1:0]  st;
    } occ_result_t;

    occ_result_t   pending_occ[$];
    logic [63:0]   exp_table[0:DEPTH];
    logic [1:0]    mode_shadow;
    logic [31:0]   beta_shadow;
    logic [31:0]   mu_shadow;
    int            error_count = 0;
    longint        cycle_count = 0;

    thermal_occupation_factor uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // exp(-y), 0 <= y < 1, 30 fraction bits, truncated series
    function automatic logic [63:0] exp_series(input logic [63:0] y);
        logic [63:0] pos, neg, term;
        pos = 64'd1 << 30;
        neg = 0;
        term = 64'd1 << 30;
        for (int n = 1; n <= 20; n++) begin
            term = ((term * y) >> 30) / n;
            if (n % 2 == 1) neg += term;
            else pos += term;
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    // exp(-a) with range reduction and table interpolation
    function automatic logic [63:0] exp_decay(input logic [63:0] a);
        logic [63:0] a30, k, r, rd, j, rem, lo, hi, v;
        a30 = a << (30 - FB);
        k = a30 / LN2_30;
        r = a30 - k * LN2_30;
        rd = r * DEPTH;
        j = rd / LN2_30;
        rem = rd % LN2_30;
        if (j >= DEPTH) j = DEPTH - 1;
        lo = exp_table[j];
        hi = exp_table[j + 1];
        v = lo - ((lo - hi) * rem) / LN2_30;
        if (k >= 31) return 64'd0;
        return v >> k;
    endfunction

    function automatic logic [63:0] div_round(input logic [63:0] num, input logic [63:0] den);
        return (num + den / 2) / den;
    endfunction

    function automatic occ_result_t predict_occupation(input logic [31:0] energy);
        longint      e, d;
        logic [63:0] m, a, u, q, den, one30, scale;
        logic        bose, fermi;
        occ_result_t res;
        one30 = 64'd1 << 30;
        scale = one30 << FB;
        e = longint'($signed(energy));
        bose = (mode_shadow == MODE_BOSE);
        fermi = (mode_shadow == MODE_FERMI);
        d = (bose || fermi) ? e - longint'($signed(mu_shadow)) : e;
        m = (d < 0) ? 64'(-d) : 64'(d);
        if (beta_shadow == 0) a = 0;
        else if (m > CLAMP_A / beta_shadow) a = CLAMP_A;
        else begin
            a = m * beta_shadow;
            if (a > CLAMP_A) a = CLAMP_A;
        end
        u = exp_decay(a);
        res.st = ST_EXACT;
        if (bose) begin
            den = one30 - u;
            if (d == 0) begin
                res.occ = SAT_POS;
                res.st = ST_POLE;
            end else if (den == 0) begin
                res.occ = (d > 0) ? SAT_POS : SAT_NEG;
                res.st = ST_SAT;
            end else if (d > 0) begin
                q = div_round(u << FB, den);
                if (q > 64'h7FFF_FFFF) begin
                    res.occ = SAT_POS;
                    res.st = ST_SAT;
                end else res.occ = q[31:0];
            end else begin
                q = div_round(scale, den);
                if (q > 64'h8000_0000) begin
                    res.occ = SAT_NEG;
                    res.st = ST_SAT;
                end else res.occ = 32'(-q);
            end
        end else if (fermi) begin
            res.occ = 32'(div_round((d >= 0) ? (u << FB) : scale, one30 + u));
        end else if (d >= 0) begin
            res.occ = 32'((u + (64'd1 << (29 - FB))) >> (30 - FB));
        end else if (u == 0) begin
            res.occ = SAT_POS;
            res.st = ST_SAT;
        end else begin
            q = div_round(scale, u);
            if (q > 64'h7FFF_FFFF) begin
                res.occ = SAT_POS;
                res.st = ST_SAT;
            end else res.occ = q[31:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
        repeat (n) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_STAT_MODE) mode_shadow = val[1:0];
        else if (idx == CFG_BETA) beta_shadow = val;
        else if (idx == CFG_MU) mu_shadow = val;
    endtask

    task automatic drain();
        while (pending_occ.size() != 0) @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    // One energy transaction; a known expectation overrides the predictor
    task automatic send_energy(input logic [31:0] energy, input bit known,
                               input occ_result_t want);
        s_tvalid = 1'b1;
        s_tdata = energy;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_occ.push_back(known ? want : predict_occupation(energy));
        @(negedge clk);
        s_tvalid = 1'b0;
        idle_gap();
    endtask

    // Result side: random stall, compare against oldest expectation
    always @(negedge clk) begin
        if ($urandom_range(0, 19) == 0) m_tready <= 1'b0;
        else if ($urandom_range(0, 3) == 0) m_tready <= ~m_tready;
        else m_tready <= 1'b1;
    end

    always @(posedge clk) begin
        occ_result_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_occ.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata, 32'd0);
            end else begin
                want = pending_occ.pop_front();
                if (m_tdata !== want.occ) report_mismatch("occupation", m_tdata, want.occ);
                if (m_tuser !== want.st) report_mismatch("status", {30'd0, m_tuser},
                                                          {30'd0, want.st});
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    typedef struct {
        logic [31:0] energy;
        bit          known;
        occ_result_t want;
    } directed_row_t;

    directed_row_t directed_rows[$];

    function automatic directed_row_t row(input logic [31:0] e, input bit k,
                                          input logic [31:0] o, input logic [1:0] s);
        directed_row_t r;
        r.energy = e;
        r.known = k;
        r.want.occ = o;
        r.want.st = s;
        return r;
    endfunction

    task automatic run_directed();
        foreach (directed_rows[i])
            send_energy(directed_rows[i].energy, directed_rows[i].known, directed_rows[i].want);
        directed_rows.delete();
    endtask

    task automatic random_phase(input int count);
        logic [31:0] e;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 4))
                0: e = $urandom;
                1: e = mu_shadow + $urandom_range(0, 8) - 4;
                2: e = mu_shadow + $urandom_range(0, 200) - 100;
                default: e = mu_shadow + $urandom_range(0, 2000000) - 1000000;
            endcase
            send_energy(e, 1'b0, '0);
            if (i == count / 2 && $urandom_range(0, 1) == 0)
                while (pending_occ.size() != 0) @(negedge clk);
        end
    endtask

    initial begin
        for (int i = 0; i <= DEPTH; i++)
            exp_table[i] = exp_series((i * LN2_30) / DEPTH);
        mode_shadow = '0;
        beta_shadow = BETA_RESET;
        mu_shadow = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: Boltzmann, beta 1.0
        directed_rows.push_back(row(32'd0, 1'b1, 32'h0001_0000, ST_EXACT));
        directed_rows.push_back(row(32'h7FFF_FFFF, 1'b1, 32'd0, ST_EXACT));
        directed_rows.push_back(row(32'h8000_0000, 1'b1, SAT_POS, ST_SAT));
        directed_rows.push_back(row(32'd1, 1'b0, '0, ST_EXACT));
        directed_rows.push_back(row(32'hFFFF_FFFF, 1'b0, '0, ST_EXACT));
        directed_rows.push_back(row(32'hFFFF_FFF0, 1'b0, '0, ST_EXACT));
        run_directed();
        drain();

        // Bose-Einstein around mu, pole and both signs
        write_reg(CFG_STAT_MODE, 32'(MODE_BOSE));
        write_reg(CFG_MU, 32'd100);
        directed_rows.push_back(row(32'd100, 1'b1, SAT_POS, ST_POLE));
        directed_rows.push_back(row(32'd101, 1'b0, '0, ST_EXACT));
        directed_rows.push_back(row(32'd99, 1'b0, '0, ST_EXACT));
        directed_rows.push_back(row(32'h7FFF_FFFF, 1'b1, 32'd0, ST_EXACT));
        directed_rows.push_back(row(32'h8000_0000, 1'b0, '0, ST_EXACT));
        run_directed();
        drain();

        // Zero beta in Bose-Einstein saturates by sign
        write_reg(CFG_BETA, 32'd0);
        directed_rows.push_back(row(32'd150, 1'b1, SAT_POS, ST_SAT));
        directed_rows.push_back(row(32'd50, 1'b1, SAT_NEG, ST_SAT));
        directed_rows.push_back(row(32'd100, 1'b1, SAT_POS, ST_POLE));
        run_directed();
        drain();

        // Fermi-Dirac with zero beta gives one half
        write_reg(CFG_STAT_MODE, 32'(MODE_FERMI));
        directed_rows.push_back(row(32'd7, 1'b1, 32'h0000_8000, ST_EXACT));
        run_directed();
        drain();
        write_reg(CFG_BETA, 32'hFFFF_FFFF);
        write_reg(CFG_MU, 32'h8000_0000);
        directed_rows.push_back(row(32'h7FFF_FFFF, 1'b0, '0, ST_EXACT));
        directed_rows.push_back(row(32'h8000_0000, 1'b0, '0, ST_EXACT));
        run_directed();
        drain();

        // Unused mode code runs as Boltzmann
        write_reg(CFG_STAT_MODE, 32'd3);
        write_reg(CFG_BETA, 32'd1);
        write_reg(CFG_MU, 32'h7FFF_FFFF);
        directed_rows.push_back(row(32'd0, 1'b1, 32'h0001_0000, ST_EXACT));
        directed_rows.push_back(row(32'hFFFF_0000, 1'b0, '0, ST_EXACT));
        run_directed();
        drain();

        // Random phases over several settings
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CFG_STAT_MODE, 32'($urandom_range(0, 3)));
            case (ph % 4)
                0: write_reg(CFG_BETA, 32'($urandom_range(1, 4096)));
                1: write_reg(CFG_BETA, $urandom | 32'd1);
                2: write_reg(CFG_BETA, 32'($urandom_range(16384, 262144)));
                default: write_reg(CFG_BETA, (ph == 3) ? 32'hFFFF_FFFF : 32'd1);
            endcase
            write_reg(CFG_MU, (ph == 5) ? 32'h7FFF_FFFF :
                              (ph == 6) ? 32'h8000_0000 :
                              32'($urandom_range(0, 2000)) - 32'd1000);
            random_phase(100);
            drain();
        end

        if (error_count == 0 && pending_occ.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
